[hdl/cubemap_bilinear_sampler_unit_macros.svh]
// Assertion macros shared by the cube-map sampler modules
`ifndef CUBEMAP_BILINEAR_SAMPLER_UNIT_MACROS_SVH
`define CUBEMAP_BILINEAR_SAMPLER_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// property holds at every rising clock edge outside reset
`define CBS_CHECK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition never holds outside reset
`define CBS_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define CBS_CHECK(lbl, clk, rst_n, prop, msg)
`define CBS_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

[hdl/cbs_pkg.sv]
// Types, codes and constants of the cube-map sampler
package cbs_pkg;
	localparam int FACES = 6;
	localparam int SZ_W  = 7;
	localparam int FC_W  = 3;
	localparam int MAG_W = 17;
	localparam int Q_W   = 23;
	localparam int NUM_W = 40;
	localparam int VAL_W = 40;

	// black test limits, exact integer form of the threshold compares
	localparam logic [41:0] LIM_SUM   = 42'((64'd255 << 32) / 64'd10000);
	localparam logic [39:0] LIM_ALPHA = 40'((64'd255 << 32) / 64'd50);

	typedef enum logic [1:0] {
		OP_WRITE  = 2'd0,
		OP_SAMPLE = 2'd1,
		OP_PEAK   = 2'd2,
		OP_NONE   = 2'd3
	} cbs_op_t;

	typedef enum logic [1:0] {
		REG_FACE_WIDTH  = 2'd0,
		REG_FACE_HEIGHT = 2'd1,
		REG_FACE_COUNT  = 2'd2,
		REG_FRAME_VALID = 2'd3
	} cbs_reg_t;

	typedef enum logic [1:0] {
		KIND_WRITE,
		KIND_SAMPLE,
		KIND_PEAK,
		KIND_NULL
	} cbs_kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_GRID,
		ST_READ,
		ST_CALC0,
		ST_CALC1,
		ST_DONE,
		ST_OUT
	} cbs_state_t;

	typedef struct packed {
		logic [SZ_W-1:0] w;
		logic [SZ_W-1:0] h;
		logic [FC_W-1:0] fc;
		logic            ready;
	} cbs_cfg_t;

	typedef struct packed {
		cbs_kind_t        kind;
		logic [2:0]       face;
		logic [5:0]       col;
		logic [5:0]       row;
		logic [31:0]      rgba;
		logic [MAG_W-1:0] nu;
		logic [MAG_W-1:0] nv;
		logic [MAG_W-1:0] m;
	} cbs_entry_t;

	// round a 32-fraction-bit channel half up to a byte
	function automatic logic [7:0] round_byte(input logic [VAL_W-1:0] v);
		logic [VAL_W:0] t;
		t = {1'b0, v} + (41'd1 << 31);
		return t[39:32];
	endfunction
endpackage

[hdl/cbs_ram.sv]
// Generic single-write, single-read RAM with registered read data
module cbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

[hdl/cbs_fifo.sv]
// Two-entry queue between the front and back parts
`include "cubemap_bilinear_sampler_unit_macros.svh"
module cbs_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  cbs_pkg::cbs_entry_t din,
	output logic                full,
	input  logic                pop,
	output cbs_pkg::cbs_entry_t dout,
	output logic                empty
);
	localparam int DEPTH = 2;

	cbs_pkg::cbs_entry_t mem_q [DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'(DEPTH));
	assign empty = (cnt_q == 2'd0);
	assign dout  = mem_q[rd_ptr_q];

	// store item
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

	`CBS_NEVER(a_fifo_over, clk, arst_n, (cnt_q > 2'(DEPTH)), "queue count above depth")
	`CBS_NEVER(a_fifo_pop_empty, clk, arst_n, (pop && cnt_q == 2'd0), "pop of empty queue")
	`CBS_CHECK(a_fifo_grow, clk, arst_n, (push && !pop |=> cnt_q == $past(cnt_q) + 2'd1), "count did not grow")
endmodule

[hdl/cbs_div.sv]
// Restoring divider, one quotient bit per cycle
module cbs_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [cbs_pkg::NUM_W-1:0]  num,
	input  logic [cbs_pkg::MAG_W-1:0]  den,
	output logic                       done,
	output logic [cbs_pkg::Q_W-1:0]    quot
);
	localparam int CNT_W = $clog2(cbs_pkg::NUM_W);

	logic [cbs_pkg::NUM_W-1:0] num_q;
	logic [cbs_pkg::MAG_W-1:0] den_q;
	logic [cbs_pkg::MAG_W-1:0] rem_q;
	logic [cbs_pkg::Q_W-1:0]   quot_q;
	logic [CNT_W-1:0]          cnt_q;
	logic                      busy_q;
	logic                      done_q;
	logic [cbs_pkg::MAG_W:0]   rem_n;
	logic                      ge;

	// shift in next numerator bit and trial subtract
	always_comb begin
		rem_n = {rem_q, num_q[cbs_pkg::NUM_W-1]};
		ge    = (rem_n >= {1'b0, den_q});
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q  <= num;
			den_q  <= den;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (busy_q) begin
			num_q  <= num_q << 1;
			rem_q  <= ge ? cbs_pkg::MAG_W'(rem_n - {1'b0, den_q}) : cbs_pkg::MAG_W'(rem_n);
			quot_q <= {quot_q[cbs_pkg::Q_W-2:0], ge};
		end
	end

	// iteration count and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(cbs_pkg::NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quot = quot_q;
endmodule

[hdl/cbs_front.sv]
// Front part: classify an item and pick the cube face of a direction
module cbs_front #(
	parameter int MAX_FACE_DIM = 64
) (
	input  logic [1:0]          op,
	input  logic [2:0]          texel_face,
	input  logic [5:0]          texel_col,
	input  logic [5:0]          texel_row,
	input  logic [31:0]         texel_rgba,
	input  logic signed [15:0]  dir_east,
	input  logic signed [15:0]  dir_up,
	input  logic signed [15:0]  dir_south,
	input  cbs_pkg::cbs_cfg_t   cfg,
	output cbs_pkg::cbs_entry_t entry
);
	logic signed [16:0] dx, dy, dz;
	logic [16:0]        ax, ay, az;
	logic signed [16:0] un, vn;
	logic [16:0]        m;
	logic [2:0]         face;
	logic signed [17:0] su, sv;
	logic               zero_dir;
	logic               wr_ok;

	// magnitudes of the direction
	always_comb begin
		dx = 17'(dir_east);
		dy = 17'(dir_up);
		dz = 17'(dir_south);
		ax = dx[16] ? 17'(-dx) : 17'(dx);
		ay = dy[16] ? 17'(-dy) : 17'(dy);
		az = dz[16] ? 17'(-dz) : 17'(dz);
		zero_dir = (ax == 17'd0) && (ay == 17'd0) && (az == 17'd0);
	end

	// face select, ties to x then y
	always_comb begin
		if (ax >= ay && ax >= az) begin
			m  = ax;
			vn = -dy;
			if (!dx[16]) begin
				face = 3'd0;
				un   = -dz;
			end else begin
				face = 3'd1;
				un   = dz;
			end
		end else if (ay >= az) begin
			m  = ay;
			un = dx;
			if (!dy[16]) begin
				face = 3'd2;
				vn   = dz;
			end else begin
				face = 3'd3;
				vn   = -dz;
			end
		end else begin
			m  = az;
			vn = -dy;
			if (!dz[16]) begin
				face = 3'd4;
				un   = dx;
			end else begin
				face = 3'd5;
				un   = -dx;
			end
		end
		su = 18'(un) + $signed({1'b0, m});
		sv = 18'(vn) + $signed({1'b0, m});
	end

	assign wr_ok = (32'(texel_face) < cbs_pkg::FACES) && (32'(texel_col) < MAX_FACE_DIM)
		&& (32'(texel_row) < MAX_FACE_DIM);

	// classify the item
	always_comb begin
		entry.face = (op == cbs_pkg::OP_WRITE) ? texel_face : face;
		entry.col  = texel_col;
		entry.row  = texel_row;
		entry.rgba = texel_rgba;
		entry.nu   = su[16:0];
		entry.nv   = sv[16:0];
		entry.m    = m;
		unique case (op)
			cbs_pkg::OP_WRITE:  entry.kind = wr_ok ? cbs_pkg::KIND_WRITE : cbs_pkg::KIND_NULL;
			cbs_pkg::OP_SAMPLE: entry.kind = (cfg.ready && !zero_dir && face < cfg.fc)
				? cbs_pkg::KIND_SAMPLE : cbs_pkg::KIND_NULL;
			cbs_pkg::OP_PEAK:   entry.kind = cfg.ready ? cbs_pkg::KIND_PEAK : cbs_pkg::KIND_NULL;
			default:            entry.kind = cbs_pkg::KIND_NULL;
		endcase
	end
endmodule

[hdl/cbs_back.sv]
// Back part: texel store, divisions, bilinear filter and result register
`include "cubemap_bilinear_sampler_unit_macros.svh"
module cbs_back #(
	parameter int MAX_FACE_DIM = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cbs_pkg::cbs_cfg_t   cfg,
	input  logic                q_valid,
	input  cbs_pkg::cbs_entry_t q_entry,
	output logic                q_pop,
	input  logic                out_ready,
	output logic                out_valid,
	output logic [7:0]          red,
	output logic [7:0]          green,
	output logic [7:0]          blue,
	output logic                got_sample,
	output logic [17:0]         peak_brightness
);
	localparam int DEPTH = cbs_pkg::FACES * MAX_FACE_DIM * MAX_FACE_DIM;
	localparam int AW    = $clog2(DEPTH);

	typedef struct packed {
		logic [6:0]  i0;
		logic [6:0]  i1;
		logic [16:0] t;
	} cbs_axis_t;

	// lower and upper grid index and weight along one axis
	function automatic cbs_axis_t grid_axis(input logic signed [24:0] g, input logic [6:0] size);
		logic signed [24:0] fl;
		logic signed [24:0] tt;
		cbs_axis_t          r;
		fl = g >>> 16;
		if (fl < 0) fl = '0;
		if (fl > $signed({18'd0, size} - 25'd1)) fl = $signed({18'd0, size} - 25'd1);
		tt = g - (fl <<< 16);
		if (tt < 0) tt = '0;
		if (tt > 25'sd65536) tt = 25'sd65536;
		r.i0 = fl[6:0];
		r.i1 = (fl[6:0] + 7'd1 < size) ? fl[6:0] + 7'd1 : size - 7'd1;
		r.t  = tt[16:0];
		return r;
	endfunction

	function automatic logic [AW-1:0] taddr(input logic [2:0] f, input logic [6:0] r,
		input logic [6:0] c);
		return AW'(f) * AW'(MAX_FACE_DIM * MAX_FACE_DIM) + AW'(r) * AW'(MAX_FACE_DIM) + AW'(c);
	endfunction

	cbs_pkg::cbs_state_t state_q, state_n;
	cbs_pkg::cbs_kind_t  kind_q;
	logic [2:0]          face_q;
	logic [6:0]          x0_q, x1_q, y0_q, y1_q;
	logic [16:0]         tx_q, ty_q;
	logic [2:0]          rd_cnt_q;
	logic [1:0]          ch_q;
	logic [31:0]         tex_q [4];
	logic [cbs_pkg::VAL_W-1:0] val_q [4];
	logic signed [26:0]  c0_s1, c1_s1;
	logic [7:0]          red_q, green_q, blue_q;
	logic                got_q;
	logic [17:0]         peak_q;

	logic                ram_we;
	logic [AW-1:0]       waddr, raddr;
	logic [31:0]         rdata;
	logic                div_start;
	logic [23:0]         pu, pv;
	logic                done_u, done_v;
	logic [cbs_pkg::Q_W-1:0] quot_u, quot_v;
	logic signed [24:0]  gx, gy;
	cbs_axis_t           axx, axy;
	logic [6:0]          rrow, rcol;
	logic [7:0]          b00, b10, b01, b11;
	logic signed [8:0]   d0, d1;
	logic signed [26:0]  c0, c1;
	logic signed [27:0]  dc;
	logic signed [44:0]  vs;
	logic [41:0]         sum;
	logic [42:0]         sum_r;
	logic [17:0]         bright;
	logic                black;
	logic                last_face;

	// texel store
	assign waddr = taddr(q_entry.face, 7'(q_entry.row), 7'(q_entry.col));
	cbs_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (waddr),
		.wdata (q_entry.rgba),
		.raddr (raddr),
		.rdata (rdata)
	);

	// grid position numerators n * size << 16 over 2m
	assign pu = 24'(q_entry.nu) * 24'(cfg.w);
	assign pv = 24'(q_entry.nv) * 24'(cfg.h);

	cbs_div u_div_u (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    ({pu, 16'd0}),
		.den    (17'({q_entry.m[15:0], 1'b0})),
		.done   (done_u),
		.quot   (quot_u)
	);

	cbs_div u_div_v (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    ({pv, 16'd0}),
		.den    (17'({q_entry.m[15:0], 1'b0})),
		.done   (done_v),
		.quot   (quot_v)
	);

	// grid indexes: divided position for samples, face center for peaks
	always_comb begin
		if (kind_q == cbs_pkg::KIND_SAMPLE) begin
			gx = $signed({2'b00, quot_u}) - 25'sd32768;
			gy = $signed({2'b00, quot_v}) - 25'sd32768;
		end else begin
			gx = $signed(25'({7'(cfg.w - 7'd1), 15'd0}));
			gy = $signed(25'({7'(cfg.h - 7'd1), 15'd0}));
		end
		axx = grid_axis(gx, cfg.w);
		axy = grid_axis(gy, cfg.h);
	end

	// texel read order: 00, 10, 01, 11
	always_comb begin
		rcol  = rd_cnt_q[0] ? x1_q : x0_q;
		rrow  = rd_cnt_q[1] ? y1_q : y0_q;
		raddr = taddr(face_q, rrow, rcol);
	end

	// one channel: blend along x, then along y
	always_comb begin
		b00 = 8'(tex_q[0] >> {ch_q, 3'b000});
		b10 = 8'(tex_q[1] >> {ch_q, 3'b000});
		b01 = 8'(tex_q[2] >> {ch_q, 3'b000});
		b11 = 8'(tex_q[3] >> {ch_q, 3'b000});
		d0  = $signed({1'b0, b10}) - $signed({1'b0, b00});
		d1  = $signed({1'b0, b11}) - $signed({1'b0, b01});
		c0  = $signed({2'b00, b00, 16'd0}) + d0 * $signed({1'b0, tx_q});
		c1  = $signed({2'b00, b01, 16'd0}) + d1 * $signed({1'b0, tx_q});
		dc  = c1_s1 - c0_s1;
		vs  = (45'(c0_s1) <<< 16) + dc * $signed({1'b0, ty_q});
	end

	// black test and center brightness
	always_comb begin
		sum       = 42'(val_q[0]) + 42'(val_q[1]) + 42'(val_q[2]);
		sum_r     = 43'(sum) + 43'h800000;
		bright    = sum_r[41:24];
		black     = (sum <= cbs_pkg::LIM_SUM) && (val_q[3] <= cbs_pkg::LIM_ALPHA);
		last_face = !(4'(face_q) + 4'd1 < 4'(cfg.fc));
	end

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			cbs_pkg::ST_IDLE: begin
				if (q_valid) begin
					unique case (q_entry.kind)
						cbs_pkg::KIND_SAMPLE: state_n = cbs_pkg::ST_DIV;
						cbs_pkg::KIND_PEAK:   state_n = cbs_pkg::ST_GRID;
						default:              state_n = cbs_pkg::ST_OUT;
					endcase
				end
			end
			cbs_pkg::ST_DIV:   if (done_u && done_v) state_n = cbs_pkg::ST_GRID;
			cbs_pkg::ST_GRID:  state_n = cbs_pkg::ST_READ;
			cbs_pkg::ST_READ:  if (rd_cnt_q == 3'd4) state_n = cbs_pkg::ST_CALC0;
			cbs_pkg::ST_CALC0: state_n = cbs_pkg::ST_CALC1;
			cbs_pkg::ST_CALC1: state_n = (ch_q == 2'd3) ? cbs_pkg::ST_DONE : cbs_pkg::ST_CALC0;
			cbs_pkg::ST_DONE: begin
				if (kind_q == cbs_pkg::KIND_PEAK && !last_face) state_n = cbs_pkg::ST_GRID;
				else state_n = cbs_pkg::ST_OUT;
			end
			cbs_pkg::ST_OUT:   if (out_ready) state_n = cbs_pkg::ST_IDLE;
			default:           state_n = cbs_pkg::ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		q_pop     = (state_q == cbs_pkg::ST_IDLE) && q_valid;
		ram_we    = q_pop && (q_entry.kind == cbs_pkg::KIND_WRITE);
		div_start = q_pop && (q_entry.kind == cbs_pkg::KIND_SAMPLE);
		out_valid = (state_q == cbs_pkg::ST_OUT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cbs_pkg::ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			cbs_pkg::ST_IDLE: begin
				if (q_valid) begin
					kind_q  <= q_entry.kind;
					face_q  <= (q_entry.kind == cbs_pkg::KIND_PEAK) ? 3'd0 : q_entry.face;
					red_q   <= '0;
					green_q <= '0;
					blue_q  <= '0;
					got_q   <= 1'b0;
					peak_q  <= '0;
				end
			end
			cbs_pkg::ST_GRID: begin
				x0_q     <= axx.i0;
				x1_q     <= axx.i1;
				tx_q     <= axx.t;
				y0_q     <= axy.i0;
				y1_q     <= axy.i1;
				ty_q     <= axy.t;
				rd_cnt_q <= '0;
				ch_q     <= '0;
			end
			cbs_pkg::ST_READ: begin
				rd_cnt_q <= rd_cnt_q + 3'd1;
				if (rd_cnt_q != 3'd0) tex_q[2'(rd_cnt_q - 3'd1)] <= rdata;
			end
			cbs_pkg::ST_CALC0: begin
				c0_s1 <= c0;
				c1_s1 <= c1;
			end
			cbs_pkg::ST_CALC1: begin
				val_q[ch_q] <= vs[cbs_pkg::VAL_W-1:0];
				ch_q        <= ch_q + 2'd1;
			end
			cbs_pkg::ST_DONE: begin
				if (kind_q == cbs_pkg::KIND_SAMPLE) begin
					got_q   <= 1'b1;
					red_q   <= black ? 8'd0 : cbs_pkg::round_byte(val_q[0]);
					green_q <= black ? 8'd0 : cbs_pkg::round_byte(val_q[1]);
					blue_q  <= black ? 8'd0 : cbs_pkg::round_byte(val_q[2]);
				end else begin
					if (bright > peak_q) peak_q <= bright;
					face_q <= face_q + 3'd1;
				end
			end
			default: begin
			end
		endcase
	end

	assign red             = red_q;
	assign green           = green_q;
	assign blue            = blue_q;
	assign got_sample      = got_q;
	assign peak_brightness = peak_q;

	`CBS_CHECK(a_pop_leaves_idle, clk, arst_n, (q_pop |=> state_q != cbs_pkg::ST_IDLE), "item stuck")
	`CBS_CHECK(a_div_lockstep, clk, arst_n, (done_u == done_v), "dividers out of step")
	`CBS_NEVER(a_sample_no_peak, clk, arst_n, (out_valid && got_q && peak_q != 18'd0), "peak on sample")
endmodule

[hdl/cubemap_bilinear_sampler_unit.sv]
// Top level of the cube-map bilinear sampler
//
//   channel | signals                                  | direction
//   in      | in_valid, in_ready, op .. dir_south      | item into block
//   out     | out_valid, out_ready, red .. peak_bright | result out of block
//   cfg     | cfg_we, cfg_index, cfg_data              | register writes
//
// Write and idle items go straight to the result state; a sample runs the
// 40-step restoring dividers, four texel reads on the single RAM read port and
// states CALC0, CALC1 per channel. A peak query repeats grid, read and filter
// steps per loaded face. A two-entry queue lets the input side keep accepting
// while the back part works or its result waits. Reset clears control state
// and sets the registers to width 64, height 64, six faces, no frame.
module cubemap_bilinear_sampler_unit #(
	parameter int MAX_FACE_DIM = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [6:0]         cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         op,
	input  logic [2:0]         texel_face,
	input  logic [5:0]         texel_col,
	input  logic [5:0]         texel_row,
	input  logic [31:0]        texel_rgba,
	input  logic signed [15:0] dir_east,
	input  logic signed [15:0] dir_up,
	input  logic signed [15:0] dir_south,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         red,
	output logic [7:0]         green,
	output logic [7:0]         blue,
	output logic               got_sample,
	output logic [17:0]        peak_brightness
);
	logic [6:0] face_width_q, face_height_q;
	logic [2:0] face_count_q;
	logic       frame_valid_q;
	cbs_pkg::cbs_cfg_t   cfg;
	cbs_pkg::cbs_entry_t f_entry, q_entry;
	logic q_full, q_empty, q_pop;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			face_width_q  <= 7'd64;
			face_height_q <= 7'd64;
			face_count_q  <= 3'd6;
			frame_valid_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cbs_pkg::REG_FACE_WIDTH:  face_width_q  <= cfg_data;
				cbs_pkg::REG_FACE_HEIGHT: face_height_q <= cfg_data;
				cbs_pkg::REG_FACE_COUNT:  face_count_q  <= cfg_data[2:0];
				cbs_pkg::REG_FRAME_VALID: frame_valid_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// saturate sizes and face count
	always_comb begin
		cfg.w  = (32'(face_width_q) > MAX_FACE_DIM) ? 7'(MAX_FACE_DIM) : face_width_q;
		cfg.h  = (32'(face_height_q) > MAX_FACE_DIM) ? 7'(MAX_FACE_DIM) : face_height_q;
		cfg.fc = (32'(face_count_q) > cbs_pkg::FACES) ? 3'(cbs_pkg::FACES) : face_count_q;
		cfg.ready = frame_valid_q && (cfg.w != 7'd0) && (cfg.h != 7'd0) && (cfg.fc != 3'd0);
	end

	assign in_ready = !q_full;

	cbs_front #(.MAX_FACE_DIM(MAX_FACE_DIM)) u_front (
		.op         (op),
		.texel_face (texel_face),
		.texel_col  (texel_col),
		.texel_row  (texel_row),
		.texel_rgba (texel_rgba),
		.dir_east   (dir_east),
		.dir_up     (dir_up),
		.dir_south  (dir_south),
		.cfg        (cfg),
		.entry      (f_entry)
	);

	cbs_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (in_valid && in_ready),
		.din    (f_entry),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (q_entry),
		.empty  (q_empty)
	);

	cbs_back #(.MAX_FACE_DIM(MAX_FACE_DIM)) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg),
		.q_valid         (!q_empty),
		.q_entry         (q_entry),
		.q_pop           (q_pop),
		.out_ready       (out_ready),
		.out_valid       (out_valid),
		.red             (red),
		.green           (green),
		.blue            (blue),
		.got_sample      (got_sample),
		.peak_brightness (peak_brightness)
	);
endmodule
